>>> hdl/hpe_pkg.sv
// Shared widths, code bases and field types for the hold-and-modify pixel encoder.
`timescale 1ns / 1ps

package hpe_pkg;

	localparam int unsigned COORD_W  = 9;
	localparam int unsigned COLOUR_W = 8;
	localparam int unsigned CHAN_W   = 6;
	localparam int unsigned CODE_W   = 8;
	localparam int unsigned OFFSET_W = 15;
	localparam int unsigned BITPOS_W = 3;
	// wide enough for (512/4) * (511 + 2) + 511/4 before wrapping to OFFSET_W
	localparam int unsigned OFFSET_CALC_W = 19;

	typedef logic [COORD_W-1:0]  coord_t;
	typedef logic [COLOUR_W-1:0] colour_t;
	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [CODE_W-1:0]   code_t;
	typedef logic [OFFSET_W-1:0] offset_t;
	typedef logic [BITPOS_W-1:0] bitpos_t;

	// six-plane code bases
	localparam code_t HAM6_RED   = 8'h20;
	localparam code_t HAM6_GREEN = 8'h30;
	localparam code_t HAM6_BLUE  = 8'h10;
	// extended code bases
	localparam code_t EXT_RED    = 8'h80;
	localparam code_t EXT_GREEN  = 8'hC0;
	localparam code_t EXT_BLUE   = 8'h40;

	// smallest code a written pixel can carry
	localparam code_t CODE_MIN = HAM6_BLUE;

endpackage

>>> hdl/ham_pixel_encoder.sv
// Hold-and-modify pixel encoder: input register, single-pass encode, result register.
//
// Pixels arrive on the pixel channel (pixel_valid / pixel_stall) with their
// position and 8-bit RGB. Each accepted pixel gives exactly one result on the
// result channel (result_valid / result_stall): pixel_written, the code, the
// byte offset within each bitplane and the first bit position. A pixel
// outside LINE_PIXELS x LINE_COUNT gives a result with every field zero.
// Each pixel is registered first in the input register and then in the result
// register, after which result valid rises; one pixel per cycle is sustained
// while the receiver does not stall. The held colour is updated as an on-screen
// pixel moves from the input register into the result register, so the next
// pixel sees it in the following cycle.
// When the receiver stalls, the result holds; the input register still takes
// one more pixel, after which pixel_stall rises until the result is taken.
// The user writes extended_mode over the mode channel (mode_ready is always high),
// and only while no pixel is in flight; the block itself does not enforce this.
// Reset empties both registers, clears the held colour and line tracking and
// selects six-plane mode.
`timescale 1ns / 1ps

module ham_pixel_encoder #(
	parameter int unsigned LINE_PIXELS = 320,
	parameter int unsigned LINE_COUNT  = 400
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             mode_valid,
	output logic             mode_ready,
	input  logic             extended_mode,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  hpe_pkg::coord_t  pixel_x,
	input  hpe_pkg::coord_t  pixel_y,
	input  hpe_pkg::colour_t red_in,
	input  hpe_pkg::colour_t green_in,
	input  hpe_pkg::colour_t blue_in,
	output logic             result_valid,
	input  logic             result_stall,
	output logic             pixel_written,
	output hpe_pkg::code_t   ham_code,
	output hpe_pkg::offset_t plane_byte_offset,
	output hpe_pkg::bitpos_t bit_position
);
	import hpe_pkg::*;

	localparam logic [COORD_W:0]       X_LIMIT    = (COORD_W+1)'(LINE_PIXELS);
	localparam logic [COORD_W:0]       Y_LIMIT    = (COORD_W+1)'(LINE_COUNT);
	localparam logic [OFFSET_CALC_W-1:0] ROW_BYTES = OFFSET_CALC_W'(LINE_PIXELS / 8);
	localparam logic [OFFSET_CALC_W-1:0] ROW_QUADS = OFFSET_CALC_W'(LINE_PIXELS / 4);

	logic    mode_q;
	logic    valid_s1;
	coord_t  x_s1, y_s1;
	colour_t red_s1, green_s1, blue_s1;

	chan_t  held_red_q, held_green_q, held_blue_q;
	coord_t current_line_q;
	logic   line_seen_q;

	logic    out_valid_q;
	logic    written_q;
	code_t   code_q;
	offset_t offset_q;
	bitpos_t bitpos_q;

	logic advance_out;
	logic take_s1;
	logic in_range;
	logic new_line;
	chan_t r, g, b, hr, hg, hb, dr, dg, db;
	logic pick_red, pick_green;
	code_t code_d;
	logic [OFFSET_CALC_W-1:0] offset_calc;
	bitpos_t bitpos_d;

	assign mode_ready    = 1'b1;
	assign advance_out   = !out_valid_q || !result_stall;
	assign take_s1       = valid_s1 && advance_out;
	assign pixel_stall   = valid_s1 && !advance_out;

	assign result_valid      = out_valid_q;
	assign pixel_written     = written_q;
	assign ham_code          = code_q;
	assign plane_byte_offset = offset_q;
	assign bit_position      = bitpos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (mode_valid && mode_ready) begin
			mode_q <= extended_mode;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pixel_stall) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!pixel_stall && pixel_valid) begin
			x_s1     <= pixel_x;
			y_s1     <= pixel_y;
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
		end
	end

	// encode
	always_comb begin
		in_range = ({1'b0, x_s1} < X_LIMIT) && ({1'b0, y_s1} < Y_LIMIT);
		if (mode_q) begin
			r = red_s1[7:2];
			g = green_s1[7:2];
			b = blue_s1[7:2];
		end else begin
			r = {2'b00, red_s1[7:4]};
			g = {2'b00, green_s1[7:4]};
			b = {2'b00, blue_s1[7:4]};
		end
		new_line = !line_seen_q || (current_line_q != y_s1);
		hr = new_line ? '0 : held_red_q;
		hg = new_line ? '0 : held_green_q;
		hb = new_line ? '0 : held_blue_q;
		dr = (r > hr) ? r - hr : hr - r;
		dg = (g > hg) ? g - hg : hg - g;
		db = (b > hb) ? b - hb : hb - b;
		// ties fall to blue, then to green
		pick_red   = (dr > dg) && (dr > db);
		pick_green = !pick_red && !(dr > dg) && (dg > db);
		if (pick_red) begin
			code_d = (mode_q ? EXT_RED : HAM6_RED) + CODE_W'(r);
		end else if (pick_green) begin
			code_d = (mode_q ? EXT_GREEN : HAM6_GREEN) + CODE_W'(g);
		end else begin
			code_d = (mode_q ? EXT_BLUE : HAM6_BLUE) + CODE_W'(b);
		end
		if (mode_q) begin
			offset_calc = ROW_QUADS * (OFFSET_CALC_W'(y_s1) + OFFSET_CALC_W'(2))
				+ OFFSET_CALC_W'(x_s1[COORD_W-1:2]);
			bitpos_d = {x_s1[1:0], 1'b0};
		end else begin
			offset_calc = ROW_BYTES * OFFSET_CALC_W'(y_s1)
				+ OFFSET_CALC_W'(x_s1[COORD_W-1:3]);
			bitpos_d = x_s1[2:0];
		end
	end

	// held colour and line tracking advance only with an encoded pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_red_q     <= '0;
			held_green_q   <= '0;
			held_blue_q    <= '0;
			current_line_q <= '0;
			line_seen_q    <= 1'b0;
		end else if (take_s1 && in_range) begin
			line_seen_q    <= 1'b1;
			current_line_q <= y_s1;
			held_red_q     <= pick_red ? r : hr;
			held_green_q   <= pick_green ? g : hg;
			held_blue_q    <= (!pick_red && !pick_green) ? b : hb;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			written_q <= in_range;
			code_q    <= in_range ? code_d : '0;
			offset_q  <= in_range ? offset_calc[OFFSET_W-1:0] : '0;
			bitpos_q  <= in_range ? bitpos_d : '0;
		end
	end

endmodule

>>> hdl/hpe_checker.sv
// Port-level checks for the hold-and-modify pixel encoder, bound to the top level.
`timescale 1ns / 1ps

module hpe_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pixel_stall,
	input logic             result_valid,
	input logic             result_stall,
	input logic             pixel_written,
	input hpe_pkg::code_t   ham_code,
	input hpe_pkg::offset_t plane_byte_offset,
	input hpe_pkg::bitpos_t bit_position
);
	import hpe_pkg::*;

	// a dropped pixel carries nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !pixel_written |->
			ham_code == '0 && plane_byte_offset == '0 && bit_position == '0)
		else $error("dropped pixel with non-zero fields");

	// a written pixel always carries a modify prefix
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pixel_written |-> ham_code >= CODE_MIN)
		else $error("written pixel with no modify prefix");

	// input is held back only while a result waits on a stalled receiver
	assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> result_valid && result_stall)
		else $error("pixel stall without a blocked result");

	// a stalled result holds until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(pixel_written)
			&& $stable(ham_code) && $stable(plane_byte_offset) && $stable(bit_position))
		else $error("stalled result changed");

endmodule

bind ham_pixel_encoder hpe_checker u_hpe_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.pixel_stall       (pixel_stall),
	.result_valid      (result_valid),
	.result_stall      (result_stall),
	.pixel_written     (pixel_written),
	.ham_code          (ham_code),
	.plane_byte_offset (plane_byte_offset),
	.bit_position      (bit_position)
);

>>> tb/ham_pixel_encoder_tb.sv
// Self-checking testbench for the hold-and-modify pixel encoder.
`timescale 1ns / 1ps

module ham_pixel_encoder_tb;
	import hpe_pkg::*;

	localparam int unsigned LINE_PIXELS    = 320;
	localparam int unsigned LINE_COUNT     = 400;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned PRINT_LIMIT    = 40;

	typedef struct packed {
		logic    written;
		code_t   code;
		offset_t offset;
		bitpos_t bitpos;
	} ham_result_t;

	// shades that quantize to equal or near-equal channels, to provoke ties
	localparam colour_t TIE_SHADES [8] = '{
		8'h00, 8'h0F, 8'h10, 8'h3F, 8'h80, 8'hC3, 8'hF0, 8'hFF
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    mode_valid = 1'b0;
	logic    mode_ready;
	logic    extended_mode = 1'b0;
	logic    pixel_valid = 1'b0;
	logic    pixel_stall;
	coord_t  pixel_x = '0;
	coord_t  pixel_y = '0;
	colour_t red_in = '0;
	colour_t green_in = '0;
	colour_t blue_in = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	logic    pixel_written;
	code_t   ham_code;
	offset_t plane_byte_offset;
	bitpos_t bit_position;

	// predictor state
	logic   model_ext = 1'b0;
	chan_t  held_red = '0;
	chan_t  held_green = '0;
	chan_t  held_blue = '0;
	coord_t held_line = '0;
	logic   line_started = 1'b0;

	ham_result_t pending_codes [$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned stall_left = 0;
	logic        idle_on = 1'b0;
	int          run_x = 0;
	int          run_y = 0;

	ham_pixel_encoder #(
		.LINE_PIXELS(LINE_PIXELS),
		.LINE_COUNT(LINE_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.mode_valid(mode_valid),
		.mode_ready(mode_ready),
		.extended_mode(extended_mode),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.pixel_written(pixel_written),
		.ham_code(ham_code),
		.plane_byte_offset(plane_byte_offset),
		.bit_position(bit_position)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic ham_result_t ham_encode(input coord_t x, input coord_t y,
			input colour_t r8, input colour_t g8, input colour_t b8);
		ham_result_t res;
		chan_t r, g, b;
		int dr, dg, db, off;
		res = '0;
		if (x >= LINE_PIXELS || y >= LINE_COUNT)
			return res;
		if (model_ext) begin
			r = r8[7:2];
			g = g8[7:2];
			b = b8[7:2];
		end else begin
			r = {2'b00, r8[7:4]};
			g = {2'b00, g8[7:4]};
			b = {2'b00, b8[7:4]};
		end
		if (!line_started || held_line != y) begin
			line_started = 1'b1;
			held_line = y;
			held_red = '0;
			held_green = '0;
			held_blue = '0;
		end
		dr = (r > held_red) ? int'(r) - int'(held_red) : int'(held_red) - int'(r);
		dg = (g > held_green) ? int'(g) - int'(held_green) : int'(held_green) - int'(g);
		db = (b > held_blue) ? int'(b) - int'(held_blue) : int'(held_blue) - int'(b);
		// red only on a strict win; green beats blue only when red did not beat green
		if (dr > dg && dr > db) begin
			held_red = r;
			res.code = (model_ext ? EXT_RED : HAM6_RED) + r;
		end else if (!(dr > dg) && dg > db) begin
			held_green = g;
			res.code = (model_ext ? EXT_GREEN : HAM6_GREEN) + g;
		end else begin
			held_blue = b;
			res.code = (model_ext ? EXT_BLUE : HAM6_BLUE) + b;
		end
		if (model_ext) begin
			off = (LINE_PIXELS / 4) * (int'(y) + 2) + int'(x) / 4;
			res.bitpos = {x[1:0], 1'b0};
		end else begin
			off = (LINE_PIXELS / 8) * int'(y) + int'(x) / 8;
			res.bitpos = x[2:0];
		end
		res.offset = offset_t'(off);
		res.written = 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// check results, predict accepted pixels, track mode writes, watch for a hang
	always @(posedge clk) begin
		ham_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_codes.size() == 0) begin
					report_mismatch("result with no pixel pending", ham_code, 0);
				end else begin
					want = pending_codes.pop_front();
					if (pixel_written !== want.written)
						report_mismatch("pixel_written", pixel_written, want.written);
					if (ham_code !== want.code)
						report_mismatch("ham_code", ham_code, want.code);
					if (plane_byte_offset !== want.offset)
						report_mismatch("plane_byte_offset", plane_byte_offset, want.offset);
					if (bit_position !== want.bitpos)
						report_mismatch("bit_position", bit_position, want.bitpos);
				end
			end
			if (pixel_valid && !pixel_stall)
				pending_codes.push_back(ham_encode(pixel_x, pixel_y, red_in, green_in,
					blue_in));
			if (mode_valid && mode_ready)
				model_ext = extended_mode;
			if ((result_valid && !result_stall) || (pixel_valid && !pixel_stall)
					|| (mode_valid && mode_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 17);
		result_stall <= (stall_left > 0);
	end

	// call just after a rising edge; returns at the edge of the transfer
	task automatic send_pixel(input coord_t x, input coord_t y, input colour_t r,
			input colour_t g, input colour_t b);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do @(posedge clk); while (pixel_stall);
	endtask

	task automatic wait_for_drain();
		pixel_valid <= 1'b0;
		do @(posedge clk); while (pending_codes.size() != 0);
	endtask

	task automatic set_mode(input logic ext);
		wait_for_drain();
		mode_valid <= 1'b1;
		extended_mode <= ext;
		do @(posedge clk); while (!mode_ready);
		mode_valid <= 1'b0;
	endtask

	function automatic colour_t pick_colour();
		if ($urandom_range(0, 9) < 4)
			return TIE_SHADES[$urandom_range(0, 7)];
		return colour_t'($urandom_range(0, 255));
	endfunction

	// mostly pixels walking along a line, the rest off-screen or scattered
	task automatic send_random_pixel();
		int kind;
		coord_t x, y;
		kind = $urandom_range(0, 99);
		if (kind < 80) begin
			if (run_x >= LINE_PIXELS || $urandom_range(0, 39) == 0) begin
				run_y = $urandom_range(0, LINE_COUNT - 1);
				run_x = $urandom_range(0, 7);
			end
			x = coord_t'(run_x);
			y = coord_t'(run_y);
			run_x++;
		end else if (kind < 85) begin
			x = coord_t'($urandom_range(LINE_PIXELS, 511));
			y = coord_t'($urandom_range(0, 511));
		end else if (kind < 90) begin
			x = coord_t'($urandom_range(0, 511));
			y = coord_t'($urandom_range(LINE_COUNT, 511));
		end else begin
			x = coord_t'($urandom_range(0, 511));
			y = coord_t'($urandom_range(0, 511));
		end
		send_pixel(x, y, pick_colour(), pick_colour(), pick_colour());
	endtask

	// six-plane mode straight out of reset, with each winner and a three-way tie
	task automatic test_reset_mode();
		send_pixel(9'd0, 9'd0, 8'h00, 8'h00, 8'h00);
		send_pixel(9'd1, 9'd0, 8'hFF, 8'h00, 8'h00);
		send_pixel(9'd2, 9'd0, 8'hFF, 8'hFF, 8'h00);
		send_pixel(9'd3, 9'd0, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(9'd319, 9'd399, 8'h80, 8'h80, 8'h80);
	endtask

	// off-screen pixels must leave the held colour alone
	task automatic test_dropped_pixels();
		send_pixel(9'd320, 9'd0, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(9'd511, 9'd511, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(9'd0, 9'd400, 8'h00, 8'hFF, 8'h00);
		send_pixel(9'd5, 9'd511, 8'hFF, 8'h00, 8'h00);
		send_pixel(9'd4, 9'd399, 8'h80, 8'h80, 8'h80);
		send_pixel(9'd6, 9'd399, 8'hF0, 8'h80, 8'hF0);
		send_pixel(9'd7, 9'd399, 8'hF0, 8'hF0, 8'h00);
	endtask

	task automatic test_extended_mode();
		set_mode(1'b1);
		send_pixel(9'd0, 9'd0, 8'h00, 8'h00, 8'h00);
		send_pixel(9'd319, 9'd0, 8'hFF, 8'h00, 8'h00);
		send_pixel(9'd170, 9'd341, 8'hAA, 8'h55, 8'hFF);
		send_pixel(9'd171, 9'd341, 8'hAA, 8'h55, 8'hFF);
		send_pixel(9'd255, 9'd399, 8'h03, 8'hFC, 8'h7F);
		send_pixel(9'd340, 9'd170, 8'hFF, 8'hFF, 8'hFF);
	endtask

	// held values carry across a mode write without conversion
	task automatic test_mode_switch_mid_line();
		send_pixel(9'd10, 9'd10, 8'hFC, 8'h00, 8'h00);
		set_mode(1'b0);
		send_pixel(9'd11, 9'd10, 8'hF0, 8'h00, 8'h00);
		send_pixel(9'd12, 9'd10, 8'h00, 8'h00, 8'h40);
		set_mode(1'b1);
		send_pixel(9'd13, 9'd10, 8'h80, 8'h80, 8'h80);
	endtask

	task automatic test_random_stream(input logic ext, input int count);
		set_mode(ext);
		repeat (count) send_random_pixel();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_mode();
		test_dropped_pixels();
		test_extended_mode();
		test_mode_switch_mid_line();
		idle_on = 1'b1;
		test_random_stream(1'b0, 220);
		test_random_stream(1'b1, 220);
		test_random_stream(1'b1, 60);
		// no idling from here to the end
		idle_on = 1'b0;
		test_random_stream(1'b0, 170);
		test_random_stream(1'b1, 180);
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
hdl/hpe_pkg.sv
hdl/ham_pixel_encoder.sv
hdl/hpe_checker.sv
tb/ham_pixel_encoder_tb.sv
